[rtl/core/sbct_pkg.sv]
// sbct_pkg: shared types and constants for the swept box collision time block
// no dependencies
package sbct_pkg;

  localparam int TIME_FRAC_BITS = 16;
  localparam int COORD_W        = 20;
  localparam int HALF_W         = 18;
  localparam int DISP_W         = COORD_W + 1;
  localparam int DIST_W         = COORD_W + 2;
  localparam int TIME_W         = TIME_FRAC_BITS + 1;
  localparam int QUOT_W         = TIME_FRAC_BITS + 2;
  localparam int NCELL          = QUOT_W;
  localparam int TCLAMP_W       = QUOT_W + 1;

  localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1) << TIME_FRAC_BITS;

  // one divider lane: remainder, dividend bits shifting out / quotient bits shifting in
  typedef struct packed {
    logic [DISP_W-1:0] rem;
    logic [QUOT_W-1:0] nq;
    logic [DISP_W-1:0] dv;
    logic              ovf;
    logic              neg;
    logic              zd;
  } lane_t;

  typedef struct packed {
    lane_t [3:0]               lanes;   // x entry, x exit, y entry, y exit
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [DISP_W-1:0]  dx;
    logic signed [DISP_W-1:0]  dy;
    logic                      solid;
  } stage_t;

endpackage

[rtl/core/sbct_if.sv]
// sbct_in_if / sbct_out_if: valid/ready channels of the collision time block
// depends on sbct_pkg
interface sbct_in_if;
  import sbct_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic [HALF_W-1:0]         half_w;
  logic [HALF_W-1:0]         half_h;
  logic signed [COORD_W-1:0] other_x;
  logic signed [COORD_W-1:0] other_y;
  logic [HALF_W-1:0]         other_half_w;
  logic [HALF_W-1:0]         other_half_h;
  logic                      solid;

  modport source (output valid, cur_x, cur_y, prev_x, prev_y, half_w, half_h,
                  other_x, other_y, other_half_w, other_half_h, solid, input ready);
  modport sink (input valid, cur_x, cur_y, prev_x, prev_y, half_w, half_h,
                other_x, other_y, other_half_w, other_half_h, solid, output ready);
endinterface

interface sbct_out_if;
  import sbct_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         hit_time;
  logic                      hit;
  logic signed [COORD_W-1:0] new_x;
  logic signed [COORD_W-1:0] new_y;

  modport source (output valid, hit_time, hit, new_x, new_y, input ready);
  modport sink (input valid, hit_time, hit, new_x, new_y, output ready);
endinterface

[rtl/core/sbct_cell.sv]
// sbct_cell: one restoring-division step for all four time lanes
// depends on sbct_pkg
module sbct_cell import sbct_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  stage_t data_i,
  output logic   valid_o,
  output stage_t data_o
);

  stage_t data_d, data_q;
  logic   valid_q;

  always_comb begin
    logic [DISP_W:0] t;
    logic            ge;
    data_d = data_i;
    for (int l = 0; l < 4; l++) begin
      t  = {data_i.lanes[l].rem, data_i.lanes[l].nq[QUOT_W-1]};
      ge = t >= {1'b0, data_i.lanes[l].dv};
      data_d.lanes[l].rem = ge ? DISP_W'(t - {1'b0, data_i.lanes[l].dv}) : t[DISP_W-1:0];
      data_d.lanes[l].nq  = {data_i.lanes[l].nq[QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/swept_box_collision_time.sv]
// swept_box_collision_time: top level, prep stage, divider cell chain, select and pull back
// depends on sbct_pkg, sbct_if, sbct_cell
//
// usage
//   in_i takes one box pair per transfer: moving box current and previous
//   centre, half extents, static box centre and half extents, solid flag
//   out_o gives one result per input transfer, in order: hit_time (Q1.16),
//   hit, and the corrected centre new_x / new_y
//   the path from input transfer to output valid runs through one prep
//   stage, 18 division cells (one quotient bit each, all four axis times in
//   parallel), one select stage, one multiply stage, one output register
//   throughput is one item per cycle while the receiver takes every result; the cell chain sets the latency
//   all stages move together; when the output holds a result that the
//   receiver does not take, the whole chain holds and in_i.ready drops
//   reset clears every stage valid bit; payload registers are not reset
module swept_box_collision_time import sbct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sbct_in_if.sink    in_i,
  sbct_out_if.source out_o
);

  // global advance: pipeline moves whenever the output register can take data
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // build one divider lane from a distance and a displacement
  function automatic lane_t make_lane(input logic signed [DIST_W-1:0] dval,
                                      input logic signed [DISP_W-1:0] disp);
    lane_t             ln;
    logic [DIST_W-1:0] an;
    logic [DISP_W-1:0] ad;
    an = dval[DIST_W-1] ? DIST_W'(-dval) : DIST_W'(dval);
    ad = disp[DISP_W-1] ? DISP_W'(-disp) : DISP_W'(disp);
    ln.zd  = (disp == '0);
    ln.dv  = ln.zd ? DISP_W'(1) : ad;
    ln.rem = DISP_W'(an[DIST_W-1:2]);
    ln.ovf = {1'b0, an[DIST_W-1:2]} >= ln.dv;
    ln.nq  = {an[1:0], {TIME_FRAC_BITS{1'b0}}};
    ln.neg = (dval != '0) && (dval[DIST_W-1] != disp[DISP_W-1]);
    return ln;
  endfunction

  // clamp a finished quotient into [-1, one + 1], enough for every compare
  function automatic logic signed [TCLAMP_W-1:0] clamp_time(input lane_t ln,
                                                            input logic is_entry);
    logic signed [TCLAMP_W-1:0] lo, hi;
    lo = -TCLAMP_W'(1);
    hi = TCLAMP_W'(TIME_ONE) + TCLAMP_W'(1);
    if (ln.zd)                                      return is_entry ? lo : hi;
    else if (ln.neg)                                return lo;
    else if (ln.ovf || {1'b0, ln.nq} > hi)          return hi;
    else                                            return {1'b0, ln.nq};
  endfunction

  // prep: displacement, entry / exit distances per axis
  stage_t prep_d;
  always_comb begin
    logic signed [DISP_W-1:0] dx, dy, ex, ey;
    logic [HALF_W:0]          sx, sy;
    logic signed [DIST_W-1:0] ex_w, ey_w, sx_w, sy_w;
    dx = DISP_W'($signed(in_i.cur_x)) - DISP_W'($signed(in_i.prev_x));
    dy = DISP_W'($signed(in_i.cur_y)) - DISP_W'($signed(in_i.prev_y));
    ex = DISP_W'($signed(in_i.cur_x)) - DISP_W'($signed(in_i.other_x));
    ey = DISP_W'($signed(in_i.cur_y)) - DISP_W'($signed(in_i.other_y));
    sx = {1'b0, in_i.half_w} + {1'b0, in_i.other_half_w};
    sy = {1'b0, in_i.half_h} + {1'b0, in_i.other_half_h};
    ex_w = DIST_W'(ex);
    ey_w = DIST_W'(ey);
    sx_w = DIST_W'({1'b0, sx});
    sy_w = DIST_W'({1'b0, sy});
    // moving positive: entry = e + s, exit = s - e; otherwise entry = s - e, exit = -e - s
    if (!dx[DISP_W-1] && dx != '0) begin
      prep_d.lanes[0] = make_lane(ex_w + sx_w, dx);
      prep_d.lanes[1] = make_lane(sx_w - ex_w, dx);
    end else begin
      prep_d.lanes[0] = make_lane(sx_w - ex_w, dx);
      prep_d.lanes[1] = make_lane(-ex_w - sx_w, dx);
    end
    if (!dy[DISP_W-1] && dy != '0) begin
      prep_d.lanes[2] = make_lane(ey_w + sy_w, dy);
      prep_d.lanes[3] = make_lane(sy_w - ey_w, dy);
    end else begin
      prep_d.lanes[2] = make_lane(sy_w - ey_w, dy);
      prep_d.lanes[3] = make_lane(-ey_w - sy_w, dy);
    end
    prep_d.cur_x = in_i.cur_x;
    prep_d.cur_y = in_i.cur_y;
    prep_d.dx    = dx;
    prep_d.dy    = dy;
    prep_d.solid = in_i.solid;
  end

  // cell chain, entry 0 is the prep register
  stage_t chain [0:NCELL];
  logic   vchain [0:NCELL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vchain[0] <= 1'b0;
    end else if (adv) begin
      vchain[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      chain[0] <= prep_d;
    end
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sbct_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vchain[k]),
      .data_i  (chain[k]),
      .valid_o (vchain[k+1]),
      .data_o  (chain[k+1])
    );
  end

  // select: latest entry against earliest exit
  logic [TIME_W-1:0] t_d;
  always_comb begin
    logic signed [TCLAMP_W-1:0] xin, xout, yin, yout, tin, tout, one_s;
    xin   = clamp_time(chain[NCELL].lanes[0], 1'b1);
    xout  = clamp_time(chain[NCELL].lanes[1], 1'b0);
    yin   = clamp_time(chain[NCELL].lanes[2], 1'b1);
    yout  = clamp_time(chain[NCELL].lanes[3], 1'b0);
    one_s = TCLAMP_W'(TIME_ONE);
    tin   = (xin > yin) ? xin : yin;
    tout  = (xout < yout) ? xout : yout;
    if (tin > tout || (xin < 0 && yin < 0) || xin > one_s || yin > one_s) begin
      t_d = TIME_ONE;
    end else begin
      t_d = tin[TIME_W-1:0];
    end
  end

  logic                      sel_valid_q, mul_valid_q;
  logic [TIME_W-1:0]         sel_t_q, mul_t_q;
  logic signed [COORD_W-1:0] sel_cx_q, sel_cy_q, mul_cx_q, mul_cy_q;
  logic signed [DISP_W-1:0]  sel_dx_q, sel_dy_q;
  logic                      sel_solid_q, mul_solid_q;
  localparam int PROD_W = DISP_W + TIME_W + 1;
  logic signed [PROD_W-1:0]  prod_x_q, prod_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      sel_valid_q <= vchain[NCELL];
      mul_valid_q <= sel_valid_q;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel_t_q     <= t_d;
      sel_cx_q    <= chain[NCELL].cur_x;
      sel_cy_q    <= chain[NCELL].cur_y;
      sel_dx_q    <= chain[NCELL].dx;
      sel_dy_q    <= chain[NCELL].dy;
      sel_solid_q <= chain[NCELL].solid;
      // displacement times time
      prod_x_q    <= PROD_W'(sel_dx_q) * PROD_W'($signed({1'b0, sel_t_q}));
      prod_y_q    <= PROD_W'(sel_dy_q) * PROD_W'($signed({1'b0, sel_t_q}));
      mul_t_q     <= sel_t_q;
      mul_cx_q    <= sel_cx_q;
      mul_cy_q    <= sel_cy_q;
      mul_solid_q <= sel_solid_q;
    end
  end

  // round half up, pull back, saturate
  function automatic logic signed [COORD_W-1:0] pull_back(
      input logic signed [COORD_W-1:0] cur, input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W:0]   p;
    logic signed [PROD_W:0]   sh;
    logic signed [PROD_W+1:0] r;
    p  = (PROD_W+1)'(prod) + ((PROD_W+1)'(1) <<< (TIME_FRAC_BITS - 1));
    sh = p >>> TIME_FRAC_BITS;
    r  = (PROD_W+2)'(cur) - (PROD_W+2)'(sh);
    if (r < (PROD_W+2)'(-(64'sd1 <<< (COORD_W - 1))))
      return {1'b1, {(COORD_W-1){1'b0}}};
    else if (r > (PROD_W+2)'((64'sd1 <<< (COORD_W - 1)) - 1))
      return {1'b0, {(COORD_W-1){1'b1}}};
    else
      return r[COORD_W-1:0];
  endfunction

  logic [TIME_W-1:0]         hit_time_q;
  logic                      hit_q;
  logic signed [COORD_W-1:0] new_x_q, new_y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_time_q <= mul_t_q;
      hit_q      <= mul_t_q < TIME_ONE;
      new_x_q    <= mul_solid_q ? pull_back(mul_cx_q, prod_x_q) : mul_cx_q;
      new_y_q    <= mul_solid_q ? pull_back(mul_cy_q, prod_y_q) : mul_cy_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.hit_time = hit_time_q;
  assign out_o.hit      = hit_q;
  assign out_o.new_x    = new_x_q;
  assign out_o.new_y    = new_y_q;

endmodule

[verif/sbct_tb_if.sv]
`timescale 1ns / 1ps
// sbct_tb_pkg: testbench types; no clocked helper interface needed beyond the rtl interfaces
// depends on sbct_pkg, which it imports directly
package sbct_tb_pkg;
  import sbct_pkg::*;

  // one box pair as driven on the input channel
  typedef struct {
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [COORD_W-1:0] prev_x;
    logic signed [COORD_W-1:0] prev_y;
    logic [HALF_W-1:0]         half_w;
    logic [HALF_W-1:0]         half_h;
    logic signed [COORD_W-1:0] other_x;
    logic signed [COORD_W-1:0] other_y;
    logic [HALF_W-1:0]         other_half_w;
    logic [HALF_W-1:0]         other_half_h;
    logic                      solid;
  } box_pair_t;

  // one collision result
  typedef struct {
    logic [TIME_W-1:0]         hit_time;
    logic                      hit;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
  } collision_t;
endpackage

[verif/tb_swept_box_collision_time.sv]
`timescale 1ns / 1ps
// tb_swept_box_collision_time: self-checking bench for the swept box collision time block
// depends on sbct_pkg, sbct_if, sbct_tb_pkg and the block itself
module tb_swept_box_collision_time;
  import sbct_pkg::*;
  import sbct_tb_pkg::*;

  localparam int    LATENCY    = 22;
  localparam int    STALL_MAX  = 4000;   // idle cycles before the watchdog fires
  localparam int    N_RANDOM   = 1830;
  localparam longint TONE      = longint'(1) << TIME_FRAC_BITS;
  localparam longint FAR       = longint'(1) << 62;

  logic clk_i;
  logic rst_ni;

  sbct_in_if  in_if ();
  sbct_out_if out_if ();

  swept_box_collision_time i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  collision_t expected_q[$];
  int         n_errors;
  int         idle_cycles;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         recv_hold;        // long receiver hold-off
  bit         stim_done;

  // floor division toward minus infinity
  function automatic longint div_floor(longint n, longint d);
    longint q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  // entry and exit time of one axis, Q.16
  function automatic void axis_window(longint c, longint p, longint h, longint o,
                                      longint oh, output longint t_in,
                                      output longint t_out);
    longint d, din, dout;
    d = c - p;
    if (d == 0) begin
      t_in  = -FAR;
      t_out = FAR;
      return;
    end
    if (d > 0) begin
      din  = c + h - o + oh;
      dout = o + oh - c + h;
    end else begin
      din  = o + oh - c + h;
      dout = o - oh - c - h;
    end
    t_in  = div_floor(din * TONE, d);
    t_out = div_floor(dout * TONE, d);
  endfunction

  // pull back by displacement times time, round half up, saturate
  function automatic longint pulled_back(longint c, longint p, longint t);
    longint r;
    r = c - div_floor((c - p) * t + (TONE >> 1), TONE);
    if (r < -524288) r = -524288;
    if (r > 524287) r = 524287;
    return r;
  endfunction

  function automatic collision_t collide(box_pair_t b);
    collision_t res;
    longint xi, xo, yi, yo, tin, tout, t;
    axis_window(b.cur_x, b.prev_x, b.half_w, b.other_x, b.other_half_w, xi, xo);
    axis_window(b.cur_y, b.prev_y, b.half_h, b.other_y, b.other_half_h, yi, yo);
    tin  = (xi > yi) ? xi : yi;
    tout = (xo < yo) ? xo : yo;
    // no hit: windows disjoint, both entries behind, or an entry past the frame
    if (tin > tout || (xi < 0 && yi < 0) || xi > TONE || yi > TONE) t = TONE;
    else t = tin;
    res.hit_time = t[TIME_W-1:0];
    res.hit      = (t < TONE);
    if (b.solid) begin
      res.new_x = COORD_W'(pulled_back(b.cur_x, b.prev_x, t));
      res.new_y = COORD_W'(pulled_back(b.cur_y, b.prev_y, t));
    end else begin
      res.new_x = b.cur_x;
      res.new_y = b.cur_y;
    end
    return res;
  endfunction

  function automatic box_pair_t make_pair(int cx, int cy, int px, int py, int hw, int hh,
                                          int ox, int oy, int ohw, int ohh, bit s);
    box_pair_t b;
    b.cur_x = COORD_W'(cx);  b.cur_y = COORD_W'(cy);
    b.prev_x = COORD_W'(px); b.prev_y = COORD_W'(py);
    b.half_w = HALF_W'(hw);  b.half_h = HALF_W'(hh);
    b.other_x = COORD_W'(ox); b.other_y = COORD_W'(oy);
    b.other_half_w = HALF_W'(ohw); b.other_half_h = HALF_W'(ohh); b.solid = s;
    return b;
  endfunction

  // random pair: mostly a box moving near an obstacle, some raw noise
  function automatic box_pair_t random_pair();
    box_pair_t b;
    int base_x, base_y, span;
    if ($urandom_range(0, 9) == 0) begin
      b.cur_x = COORD_W'($urandom);  b.cur_y = COORD_W'($urandom);
      b.prev_x = COORD_W'($urandom); b.prev_y = COORD_W'($urandom);
      b.half_w = HALF_W'($urandom);  b.half_h = HALF_W'($urandom);
      b.other_x = COORD_W'($urandom); b.other_y = COORD_W'($urandom);
      b.other_half_w = HALF_W'($urandom); b.other_half_h = HALF_W'($urandom);
    end else begin
      span   = (1 << $urandom_range(4, 16));
      base_x = $signed($urandom_range(0, 900000)) - 450000;
      base_y = $signed($urandom_range(0, 900000)) - 450000;
      b.other_x = COORD_W'(base_x);
      b.other_y = COORD_W'(base_y);
      b.other_half_w = HALF_W'($urandom_range(0, span));
      b.other_half_h = HALF_W'($urandom_range(0, span));
      b.half_w = HALF_W'($urandom_range(0, span));
      b.half_h = HALF_W'($urandom_range(0, span));
      b.cur_x  = COORD_W'(base_x + $signed($urandom_range(0, 4 * span)) - 2 * span);
      b.cur_y  = COORD_W'(base_y + $signed($urandom_range(0, 4 * span)) - 2 * span);
      // zero displacement on an axis now and then
      b.prev_x = ($urandom_range(0, 7) == 0) ? b.cur_x
               : COORD_W'(int'(b.cur_x) + $signed($urandom_range(0, 8 * span)) - 4 * span);
      b.prev_y = ($urandom_range(0, 7) == 0) ? b.cur_y
               : COORD_W'(int'(b.cur_y) + $signed($urandom_range(0, 8 * span)) - 4 * span);
    end
    b.solid = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // directed table; a typed-in result is checked against the predictor too
  box_pair_t  dir_pair[$];
  collision_t dir_known[$];
  bit         dir_has[$];

  task automatic add_row(box_pair_t b, bit has, collision_t r);
    dir_pair.push_back(b);
    dir_has.push_back(has);
    dir_known.push_back(r);
  endtask

  task automatic build_table();
    collision_t r, none;
    none = '{default: '0};
    // still box: no hit, time one, centre unchanged
    r = '{hit_time: TIME_ONE, hit: 1'b0, new_x: 20'sd1000, new_y: -20'sd2000};
    add_row(make_pair(1000, -2000, 1000, -2000, 10, 10, 0, 0, 10, 10, 1), 1, r);
    // all zero, solid and not
    r = '{hit_time: TIME_ONE, hit: 1'b0, new_x: '0, new_y: '0};
    add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, r);
    add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, r);
    // extremes of every field
    add_row(make_pair(524287, 524287, -524288, -524288, 262143, 262143,
                      524287, 524287, 262143, 262143, 1), 0, none);
    add_row(make_pair(-524288, -524288, 524287, 524287, 262143, 262143,
                      -524288, -524288, 262143, 262143, 1), 0, none);
    add_row(make_pair(524287, -524288, -524288, 524287, 0, 262143,
                      -524288, 524287, 262143, 0, 1), 0, none);
    add_row(make_pair(-524288, 524287, 524287, -524288, 262143, 0,
                      524287, -524288, 0, 262143, 0), 0, none);
    // head-on along x, positive and negative displacement
    add_row(make_pair(1000, 0, 0, 0, 100, 100, 1100, 0, 100, 100, 1), 0, none);
    add_row(make_pair(-1000, 0, 0, 0, 100, 100, -1100, 0, 100, 100, 1), 0, none);
    // along y only
    add_row(make_pair(0, 2560, 0, -256, 64, 64, 0, 2600, 64, 64, 1), 0, none);
    add_row(make_pair(0, -2560, 0, 256, 64, 64, 0, -2600, 64, 64, 1), 0, none);
    // diagonal, both axes
    add_row(make_pair(500, 500, -500, -500, 50, 50, 400, 400, 50, 50, 1), 0, none);
    // touching exactly at the current centres: entry zero, hit at time zero
    add_row(make_pair(100, 0, 0, 0, 10, 10, 120, 0, 10, 10, 1), 0, none);
    // moving away: both entries behind
    add_row(make_pair(-500, -500, 0, 0, 10, 10, 100, 100, 10, 10, 1), 0, none);
    // passes beside, windows disjoint
    add_row(make_pair(1000, 0, -1000, -5000, 10, 10, 0, 20000, 10, 10, 1), 0, none);
    // already overlapping
    add_row(make_pair(10, 10, 0, 0, 100, 100, 0, 0, 100, 100, 1), 0, none);
    add_row(make_pair(10, 10, 0, 0, 100, 100, 0, 0, 100, 100, 0), 0, none);
    // pull back landing exactly on the largest coordinate
    add_row(make_pair(-524288, 0, 524287, 0, 262143, 0, 524287, 0, 262143, 0, 1), 0, none);
    // displacement of one
    add_row(make_pair(1, 1, 0, 0, 0, 0, 1, 1, 0, 0, 1), 0, none);
  endtask

  // drive one item and wait for its transfer; valid stays high afterwards
  task automatic send(box_pair_t b);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.cur_x        <= b.cur_x;
    in_if.cur_y        <= b.cur_y;
    in_if.prev_x       <= b.prev_x;
    in_if.prev_y       <= b.prev_y;
    in_if.half_w       <= b.half_w;
    in_if.half_h       <= b.half_h;
    in_if.other_x      <= b.other_x;
    in_if.other_y      <= b.other_y;
    in_if.other_half_w <= b.other_half_w;
    in_if.other_half_h <= b.other_half_h;
    in_if.solid        <= b.solid;
    do @(posedge clk_i); while (!in_if.ready);
    expected_q.push_back(collide(b));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    collision_t pred;
    in_if.valid = 1'b0;
    in_if.cur_x = '0; in_if.cur_y = '0; in_if.prev_x = '0; in_if.prev_y = '0;
    in_if.half_w = '0; in_if.half_h = '0; in_if.other_x = '0; in_if.other_y = '0;
    in_if.other_half_w = '0; in_if.other_half_h = '0; in_if.solid = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold     = 1'b0;
    stim_done     = 1'b0;
    n_errors      = 0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    build_table();
    foreach (dir_pair[i]) begin
      // typed-in rows must agree with the predictor
      if (dir_has[i]) begin
        pred = collide(dir_pair[i]);
        if (pred.hit_time !== dir_known[i].hit_time) begin
          $error("row %0d hit_time: expected %0d, got %0d", i, dir_known[i].hit_time,
                 pred.hit_time);
          n_errors++;
        end
        if (pred.hit !== dir_known[i].hit) begin
          $error("row %0d hit: expected %0d, got %0d", i, dir_known[i].hit, pred.hit);
          n_errors++;
        end
        if (pred.new_x !== dir_known[i].new_x) begin
          $error("row %0d new_x: expected %0d, got %0d", i, dir_known[i].new_x, pred.new_x);
          n_errors++;
        end
        if (pred.new_y !== dir_known[i].new_y) begin
          $error("row %0d new_y: expected %0d, got %0d", i, dir_known[i].new_y, pred.new_y);
          n_errors++;
        end
      end
      send(dir_pair[i]);
    end

    // sender pauses until every result is back
    drain();

    // long receiver hold-off while the sender keeps offering
    recv_hold = 1'b1;
    for (int i = 0; i < 60; i++) send(random_pair());
    drain();

    send_idle_pct = 23;
    recv_idle_pct = 77;
    for (int i = 0; i < N_RANDOM / 3; i++) send(random_pair());
    send_idle_pct = 77;
    recv_idle_pct = 23;
    for (int i = 0; i < N_RANDOM / 3; i++) send(random_pair());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < N_RANDOM / 3 - 60; i++) send(random_pair());

    drain();
    repeat (LATENCY + 5) @(negedge clk_i);
    stim_done = 1'b1;
  end

  // receiver ready, with the long hold-off counted here
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (recv_hold) begin
        out_if.ready <= 1'b0;
        repeat (200) @(negedge clk_i);
        recv_hold = 1'b0;
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= !(recv_idle_pct > 0 && $urandom_range(1, 100) <= recv_idle_pct);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    collision_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_if.hit_time !== want.hit_time) begin
          $error("hit_time: expected %0d, got %0d", want.hit_time, out_if.hit_time);
          n_errors++;
        end
        if (out_if.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_if.hit);
          n_errors++;
        end
        if (out_if.new_x !== want.new_x) begin
          $error("new_x: expected %0d, got %0d", want.new_x, out_if.new_x);
          n_errors++;
        end
        if (out_if.new_y !== want.new_y) begin
          $error("new_y: expected %0d, got %0d", want.new_y, out_if.new_y);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer, and the end of the run
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (stim_done) begin
        if (expected_q.size() != 0) n_errors++;
        if (n_errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
